// ===== rtl/lgrs_pkg.sv =====
// ============================================================================
// lgrs_pkg
// Shared types, constants and helpers for the Life row stencil unit.
// ============================================================================
package lgrs_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int WIDTH_W     = 7;
    localparam int RES_DEPTH   = 4;
    localparam int RES_PTR_W   = $clog2(RES_DEPTH);
    localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(MAX_COLUMNS);

    typedef logic [MAX_COLUMNS-1:0] row_t;

    typedef struct packed {
        row_t row_cells;
        logic last_row;
    } lgrs_in_t;

    typedef struct packed {
        row_t next_cells;
        logic grid_done;
    } lgrs_out_t;

    // The 3x3 neighbourhood of one cell; bit 1 of each row is the cell's column.
    typedef struct packed {
        logic [2:0] up;
        logic [2:0] mid;
        logic [2:0] down;
    } lgrs_window_t;

    // Columns below the width in use are set; widths above the maximum saturate.
    function automatic row_t column_mask(input logic [WIDTH_W-1:0] width);
        logic [WIDTH_W-1:0] w;
        row_t               m;
        w = width;
        if (w > WIDTH_W'(MAX_COLUMNS))
        begin
            w = WIDTH_W'(MAX_COLUMNS);
        end
        for (int c = 0; c < MAX_COLUMNS; c++)
        begin
            m[c] = (WIDTH_W'(c) < w);
        end
        return m;
    endfunction

endpackage

// ===== rtl/lgrs_cell_lane.sv =====
// ============================================================================
// lgrs_cell_lane
// Next-generation state of a single cell from its 3x3 neighbourhood (B3/S23).
// ============================================================================
module lgrs_cell_lane (
    input  lgrs_pkg::lgrs_window_t window,
    output logic                   alive
);

    logic [3:0] neighbours;

    assign neighbours = 4'(window.up[0])   + 4'(window.up[1])   + 4'(window.up[2])
                      + 4'(window.mid[0])                        + 4'(window.mid[2])
                      + 4'(window.down[0]) + 4'(window.down[1]) + 4'(window.down[2]);

    // Born with three neighbours, survives with two or three.
    assign alive = (neighbours == 4'd3) || (window.mid[1] && (neighbours == 4'd2));

endmodule

// ===== rtl/lgrs_row_evolve.sv =====
// ============================================================================
// lgrs_row_evolve
// One lane per column evaluates a cell; the merge stage gathers the lane
// outputs into a row and clears the columns outside the width in use.
// ============================================================================
module lgrs_row_evolve (
    input  lgrs_pkg::row_t up,
    input  lgrs_pkg::row_t mid,
    input  lgrs_pkg::row_t down,
    input  lgrs_pkg::row_t mask,
    output lgrs_pkg::row_t next_row
);

    localparam int PAD_W = lgrs_pkg::MAX_COLUMNS + 2;

    // Padded with a dead column on each side so the edge lanes see no neighbour.
    logic [PAD_W-1:0] up_pad;
    logic [PAD_W-1:0] mid_pad;
    logic [PAD_W-1:0] down_pad;
    lgrs_pkg::row_t   lane_alive;

    assign up_pad   = {1'b0, up   & mask, 1'b0};
    assign mid_pad  = {1'b0, mid  & mask, 1'b0};
    assign down_pad = {1'b0, down & mask, 1'b0};

    for (genvar c = 0; c < lgrs_pkg::MAX_COLUMNS; c++)
    begin : g_lane
        lgrs_pkg::lgrs_window_t window;

        assign window.up   = up_pad[c +: 3];
        assign window.mid  = mid_pad[c +: 3];
        assign window.down = down_pad[c +: 3];

        lgrs_cell_lane u_lane (
            .window (window),
            .alive  (lane_alive[c])
        );
    end

    assign next_row = lane_alive & mask;

endmodule

// ===== rtl/life_generation_row_stencil_unit.sv =====
// ============================================================================
// life_generation_row_stencil_unit
// Streams one B3/S23 Life generation over a dead-bordered grid, row by row.
// ============================================================================
// Rows of the current generation enter top to bottom on the item channel, one
// row per beat, with last_row set on the bottom row. The first row of a grid
// produces nothing; every later row produces the next generation of the row
// above it, and the bottom row produces a second beat, marked grid_done, for
// itself. A one-row grid gives a single beat with grid_done set.
// The cfg channel writes width_in_use (reset 64) and is always ready. The
// user must see that it is written only while no result is queued; the block
// does not enforce this. Columns at or beyond the width read as dead and come
// out as zero. Both results of a row are worked out by two sets of 64 column
// lanes in the cycle the row is accepted and land in a four-entry result
// queue, where each is offered once the results ahead of it have been taken.
// One row is taken per cycle while two queue entries are free, so with a steady
// receiver and grids of two or more rows the rate is one row per cycle.
// When result_stall is held the queue fills and item_stall rises; nothing is
// dropped. Reset empties the queue, forgets held rows and restores width 64.
// ============================================================================
module life_generation_row_stencil_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lgrs_pkg::WIDTH_W-1:0]  cfg_data,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  lgrs_pkg::lgrs_in_t            item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output lgrs_pkg::lgrs_out_t           result
);

    logic [lgrs_pkg::WIDTH_W-1:0]   width_reg;
    lgrs_pkg::row_t                 row_above_reg;
    lgrs_pkg::row_t                 row_above_next;
    lgrs_pkg::row_t                 row_middle_reg;
    lgrs_pkg::row_t                 row_middle_next;
    logic                           middle_held_reg;
    logic                           middle_held_next;

    lgrs_pkg::lgrs_out_t            res_mem [lgrs_pkg::RES_DEPTH];
    logic [lgrs_pkg::RES_PTR_W-1:0] wr_ptr_reg;
    logic [lgrs_pkg::RES_PTR_W-1:0] rd_ptr_reg;
    logic [lgrs_pkg::RES_CNT_W-1:0] count_reg;
    logic [lgrs_pkg::RES_CNT_W-1:0] count_next;

    lgrs_pkg::row_t                 mask;
    lgrs_pkg::row_t                 row_in;
    lgrs_pkg::row_t                 held_result;
    lgrs_pkg::row_t                 bottom_result;
    logic                           accept;
    logic                           pop;
    logic                           push_held;
    logic                           push_bottom;
    logic [lgrs_pkg::RES_PTR_W-1:0] bottom_ptr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= lgrs_pkg::WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            width_reg <= cfg_data;
        end
    end

    assign mask   = lgrs_pkg::column_mask(width_reg);
    assign row_in = item.row_cells & mask;

    // Held row against its lower neighbour.
    lgrs_row_evolve u_held (
        .up       (row_above_reg),
        .mid      (row_middle_reg),
        .down     (row_in),
        .mask     (mask),
        .next_row (held_result)
    );

    // Bottom row against a dead row below; the middle row is zero when none is held.
    lgrs_row_evolve u_bottom (
        .up       (row_middle_reg),
        .mid      (row_in),
        .down     ('0),
        .mask     (mask),
        .next_row (bottom_result)
    );

    // Room for two beats is required so a bottom row can always queue both.
    assign item_stall   = (count_reg > lgrs_pkg::RES_CNT_W'(lgrs_pkg::RES_DEPTH - 2));
    assign accept       = item_valid && !item_stall;
    assign push_held    = accept && middle_held_reg;
    assign push_bottom  = accept && item.last_row;
    assign bottom_ptr   = wr_ptr_reg + lgrs_pkg::RES_PTR_W'(push_held);

    assign result_valid = (count_reg != '0);
    assign result       = res_mem[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;

    assign count_next = count_reg
                      + lgrs_pkg::RES_CNT_W'(push_held)
                      + lgrs_pkg::RES_CNT_W'(push_bottom)
                      - lgrs_pkg::RES_CNT_W'(pop);

    always_comb
    begin
        row_above_next   = row_above_reg;
        row_middle_next  = row_middle_reg;
        middle_held_next = middle_held_reg;
        if (accept)
        begin
            if (item.last_row)
            begin
                row_above_next   = '0;
                row_middle_next  = '0;
                middle_held_next = 1'b0;
            end
            else
            begin
                row_above_next   = middle_held_reg ? row_middle_reg : '0;
                row_middle_next  = row_in;
                middle_held_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_above_reg   <= '0;
            row_middle_reg  <= '0;
            middle_held_reg <= 1'b0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            row_above_reg   <= row_above_next;
            row_middle_reg  <= row_middle_next;
            middle_held_reg <= middle_held_next;
            wr_ptr_reg      <= wr_ptr_reg
                             + lgrs_pkg::RES_PTR_W'(push_held)
                             + lgrs_pkg::RES_PTR_W'(push_bottom);
            rd_ptr_reg      <= rd_ptr_reg + lgrs_pkg::RES_PTR_W'(pop);
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_held)
        begin
            res_mem[wr_ptr_reg] <= '{next_cells: held_result, grid_done: 1'b0};
        end
        if (push_bottom)
        begin
            res_mem[bottom_ptr] <= '{next_cells: bottom_result, grid_done: 1'b1};
        end
    end

    a_count_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lgrs_pkg::RES_CNT_W'(lgrs_pkg::RES_DEPTH))
        else $error("result queue count beyond its depth");

    a_accept_has_room : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> count_reg <= lgrs_pkg::RES_CNT_W'(lgrs_pkg::RES_DEPTH - 2))
        else $error("row accepted without room for two results");

    a_last_clears_window : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.last_row) |=> (!middle_held_reg && row_middle_reg == '0
                                        && row_above_reg == '0))
        else $error("row window not cleared after the bottom row");

    a_unheld_window_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !middle_held_reg |-> (row_middle_reg == '0 && row_above_reg == '0))
        else $error("stale rows kept while no row is held");

    a_push_makes_valid : assert property (@(posedge clk) disable iff (!rst_n)
        (push_held || push_bottom) |=> result_valid)
        else $error("queued result not presented");

endmodule
